[hdl/wrg_pkg.sv]
// ----------------------------------------------------------------------------
// wrg_pkg
// shared constants and control types for the radius of gyration block
// ----------------------------------------------------------------------------
package wrg_pkg;

  localparam int DEF_MAX_POINTS = 4096;
  localparam int COORD_W        = 16;
  localparam int WEIGHT_W       = 16;
  localparam int STATUS_W       = 2;
  localparam int DIV_W          = 64;
  localparam int SPREAD_W       = 64;
  localparam int ROOT_W         = 32;
  localparam int SQ_W           = 35;
  localparam int ENTRY_W        = 3 * COORD_W + WEIGHT_W;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] SEL_X   = 2'd0;
  localparam logic [1:0] SEL_Y   = 2'd1;
  localparam logic [1:0] SEL_Z   = 2'd2;
  localparam logic [1:0] SEL_VAR = 2'd3;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       scan_start;
    logic       sqrt_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic sqrt_done;
    logic ovf;
    logic tw_zero;
    logic out_free;
  } sts_t;

endpackage

[hdl/wrg_if.sv]
// ----------------------------------------------------------------------------
// wrg_if
// point and result channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface wrg_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wrg_pkg::COORD_W-1:0]    x_coord;
  logic signed [wrg_pkg::COORD_W-1:0]    y_coord;
  logic signed [wrg_pkg::COORD_W-1:0]    z_coord;
  logic        [wrg_pkg::WEIGHT_W-1:0]   weight;
  logic                                  last_point;
  modport source (output valid, x_coord, y_coord, z_coord, weight, last_point,
                  input ready);
  modport sink (input valid, x_coord, y_coord, z_coord, weight, last_point,
                output ready);
endinterface

interface wrg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wrg_pkg::COORD_W-1:0]    centroid_x;
  logic signed [wrg_pkg::COORD_W-1:0]    centroid_y;
  logic signed [wrg_pkg::COORD_W-1:0]    centroid_z;
  logic        [wrg_pkg::COORD_W-1:0]    radius;
  logic        [wrg_pkg::STATUS_W-1:0]   status;
  modport source (output valid, centroid_x, centroid_y, centroid_z, radius, status,
                  input ready);
  modport sink (input valid, centroid_x, centroid_y, centroid_z, radius, status,
                output ready);
endinterface

[hdl/wrg_div.sv]
// ----------------------------------------------------------------------------
// wrg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wrg_div #(
  parameter int DW = 64,
  parameter int VW = 29
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);
  localparam int NW = $clog2(DW);

  logic [VW:0]   rem_r, rem_nxt, rem_s;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic          qbit;

  always_comb begin
    rem_s    = {rem_r[VW-1:0], quo_r[DW-1]};
    qbit     = (rem_s >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? (rem_s - {1'b0, dvs_r}) : rem_s;
      quo_nxt = {quo_r[DW-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == NW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (start) dvs_r <= divisor;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
endmodule

[hdl/wrg_dp.sv]
// ----------------------------------------------------------------------------
// wrg_dp
// point memory, sums, spread pipeline, shared divider, square root, output
// ----------------------------------------------------------------------------
module wrg_dp #(
  parameter int MAX_POINTS = wrg_pkg::DEF_MAX_POINTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wrg_pkg::cmd_t       cmd,
  output wrg_pkg::sts_t       sts,
  wrg_in_if.sink              in_ch,
  wrg_out_if.source           out_ch
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW = wrg_pkg::WEIGHT_W + CW;
  localparam int SW = 2 * wrg_pkg::COORD_W + CW;
  localparam int CD = wrg_pkg::COORD_W;
  localparam int TM = wrg_pkg::SQ_W + wrg_pkg::WEIGHT_W;

  logic [wrg_pkg::ENTRY_W-1:0] mem [MAX_POINTS];
  logic [wrg_pkg::ENTRY_W-1:0] rd_r;

  logic [CW-1:0]        cnt_r;
  logic signed [SW-1:0] sum_r [3];
  logic [TW-1:0]        tw_r;
  logic                 ovf_r;
  logic [wrg_pkg::SPREAD_W-1:0] spr_r;
  logic signed [CD-1:0] cen_r [3];
  logic                 full;

  logic signed [CD:0]   prod_w;
  logic signed [2*CD:0] prod [3];
  logic signed [CD-1:0] coord [3];

  always_comb begin
    coord[0] = in_ch.x_coord;
    coord[1] = in_ch.y_coord;
    coord[2] = in_ch.z_coord;
    prod_w   = $signed({1'b0, in_ch.weight});
    for (int k = 0; k < 3; k++) prod[k] = coord[k] * prod_w;
  end

  assign full = (cnt_r == CW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (cmd.load && !full)
      mem[cnt_r[AW-1:0]] <= {in_ch.weight, in_ch.z_coord, in_ch.y_coord, in_ch.x_coord};
  end

  // divider operand select
  logic [1:0]          sel_r;
  logic                neg_r;
  logic signed [SW-1:0] dsum;
  logic [SW-1:0]       mag;
  logic [wrg_pkg::DIV_W-1:0] dvd, quot;
  logic                div_done;

  always_comb begin
    dsum = sum_r[0];
    case (cmd.div_sel)
      wrg_pkg::SEL_Y: dsum = sum_r[1];
      wrg_pkg::SEL_Z: dsum = sum_r[2];
      default:        dsum = sum_r[0];
    endcase
    mag = dsum[SW-1] ? SW'(-dsum) : SW'(dsum);
    if (cmd.div_sel == wrg_pkg::SEL_VAR) dvd = spr_r;
    else dvd = wrg_pkg::DIV_W'(mag) + wrg_pkg::DIV_W'(tw_r >> 1);
  end

  wrg_div #(.DW(wrg_pkg::DIV_W), .VW(TW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dvd),
    .divisor(tw_r), .done(div_done), .quot(quot)
  );

  logic [CD:0]   qc, qs;
  assign qc = quot[CD:0];
  assign qs = neg_r ? (-qc) : qc;

  // spread pipeline
  logic [AW-1:0] idx_r;
  logic          act_r, run_r, v0_r, v1_r, v2_r;
  logic signed [CD:0]   dd [3];
  logic signed [2*CD+1:0] dsq [3];
  logic [wrg_pkg::SQ_W-1:0] sq_c, sq_r;
  logic [wrg_pkg::WEIGHT_W-1:0] w1_r;
  logic [TM-1:0] term_r;
  logic [wrg_pkg::SPREAD_W:0] spr_s;
  logic [CW-1:0] last_c;
  logic          scan_done;

  assign last_c = cnt_r - 1'b1;

  always_comb begin
    sq_c = '0;
    for (int k = 0; k < 3; k++) begin
      dd[k] = $signed({rd_r[CD*k+CD-1], rd_r[CD*k +: CD]})
            - $signed({cen_r[k][CD-1], cen_r[k]});
      dsq[k] = dd[k] * dd[k];
      sq_c  = sq_c + wrg_pkg::SQ_W'($unsigned(dsq[k]));
    end
    spr_s = {1'b0, spr_r} + (wrg_pkg::SPREAD_W + 1)'(term_r);
  end

  assign scan_done = run_r && !act_r && !v0_r && !v1_r && !v2_r;

  // square root, restoring, result built bit-serially
  localparam int ROOT_W_L = wrg_pkg::ROOT_W;
  logic [wrg_pkg::DIV_W-1:0] sv_r;
  logic [ROOT_W_L-1:0]       root_r;
  logic [ROOT_W_L+3:0]       srem_r, srem_s, strial;
  logic [4:0]                scnt_r;
  logic                      sbusy_r, sdone_r, sge;

  always_comb begin
    srem_s = {srem_r[ROOT_W_L+1:0], sv_r[wrg_pkg::DIV_W-1 -: 2]};
    strial = (ROOT_W_L + 4)'({root_r, 2'b01});
    sge    = (srem_s >= strial);
  end

  logic [CD-1:0] radius_c;
  assign radius_c = (root_r[ROOT_W_L-1:CD] != '0) ? '1 : root_r[CD-1:0];

  logic out_valid_r;
  logic signed [CD-1:0] ocx_r, ocy_r, ocz_r;
  logic [CD-1:0] orad_r;
  logic [wrg_pkg::STATUS_W-1:0] ost_r;

  always_ff @(posedge clk) begin
    rd_r <= mem[idx_r];
    if (cmd.div_start) begin
      sel_r <= cmd.div_sel;
      neg_r <= (cmd.div_sel != wrg_pkg::SEL_VAR) && dsum[SW-1];
    end
    if (div_done) begin
      case (sel_r)
        wrg_pkg::SEL_X: cen_r[0] <= qs[CD-1:0];
        wrg_pkg::SEL_Y: cen_r[1] <= qs[CD-1:0];
        wrg_pkg::SEL_Z: cen_r[2] <= qs[CD-1:0];
        default:        sv_r     <= quot;
      endcase
    end
    sq_r   <= sq_c;
    w1_r   <= rd_r[wrg_pkg::ENTRY_W-1 -: wrg_pkg::WEIGHT_W];
    term_r <= sq_r * w1_r;
    if (cmd.sqrt_start) begin
      srem_r <= '0;
      root_r <= '0;
      scnt_r <= '0;
    end else if (sbusy_r) begin
      srem_r <= sge ? (srem_s - strial) : srem_s;
      root_r <= {root_r[ROOT_W_L-2:0], sge};
      sv_r   <= {sv_r[wrg_pkg::DIV_W-3:0], 2'b00};
      scnt_r <= scnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      if (ovf_r || tw_r == '0) begin
        ocx_r  <= '0;
        ocy_r  <= '0;
        ocz_r  <= '0;
        orad_r <= '0;
        ost_r  <= ovf_r ? wrg_pkg::ST_OVF : wrg_pkg::ST_ZERO;
      end else begin
        ocx_r  <= cen_r[0];
        ocy_r  <= cen_r[1];
        ocz_r  <= cen_r[2];
        orad_r <= radius_c;
        ost_r  <= wrg_pkg::ST_OK;
      end
    end
    if (!rst_n) begin
      cnt_r <= '0;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
      tw_r  <= '0;
      ovf_r <= 1'b0;
      spr_r <= '0;
      act_r <= 1'b0;
      run_r <= 1'b0;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      idx_r <= '0;
      sbusy_r <= 1'b0;
      sdone_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        cnt_r <= '0;
        for (int k = 0; k < 3; k++) sum_r[k] <= '0;
        tw_r  <= '0;
        ovf_r <= 1'b0;
        spr_r <= '0;
      end else if (cmd.load) begin
        if (full) ovf_r <= 1'b1;
        else begin
          cnt_r <= cnt_r + 1'b1;
          for (int k = 0; k < 3; k++) sum_r[k] <= sum_r[k] + SW'(prod[k]);
          tw_r  <= tw_r + TW'(in_ch.weight);
        end
      end else if (v2_r) begin
        spr_r <= spr_s[wrg_pkg::SPREAD_W] ? '1 : spr_s[wrg_pkg::SPREAD_W-1:0];
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
        act_r <= 1'b1;
        run_r <= 1'b1;
      end else begin
        if (act_r) begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == last_c[AW-1:0]) act_r <= 1'b0;
        end
        if (scan_done) run_r <= 1'b0;
      end
      v0_r <= act_r;
      v1_r <= v0_r;
      v2_r <= v1_r;
      sdone_r <= 1'b0;
      if (cmd.sqrt_start) sbusy_r <= 1'b1;
      else if (sbusy_r && scnt_r == 5'd31) begin
        sbusy_r <= 1'b0;
        sdone_r <= 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.scan_done = scan_done;
  assign sts.sqrt_done = sdone_r;
  assign sts.ovf       = ovf_r;
  assign sts.tw_zero   = (tw_r == '0);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.centroid_x = ocx_r;
  assign out_ch.centroid_y = ocy_r;
  assign out_ch.centroid_z = ocz_r;
  assign out_ch.radius     = orad_r;
  assign out_ch.status     = ost_r;
endmodule

[hdl/wrg_ctrl.sv]
// ----------------------------------------------------------------------------
// wrg_ctrl
// sequencer: load, centroid divides, spread pass, variance divide, root, emit
// ----------------------------------------------------------------------------
module wrg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  wrg_pkg::sts_t sts,
  output wrg_pkg::cmd_t cmd
);
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIVC = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DIVV = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  assign in_ready = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.load  = in_valid && in_ready;
    unique case (state_r)
      S_LOAD: if (in_valid && in_last) state_nxt = S_CHK;
      S_CHK: begin
        if (sts.ovf || sts.tw_zero) state_nxt = S_OUT;
        else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = wrg_pkg::SEL_X;
          sel_nxt       = wrg_pkg::SEL_X;
          state_nxt     = S_DIVC;
        end
      end
      S_DIVC: begin
        if (sts.div_done) begin
          if (sel_r == wrg_pkg::SEL_Z) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            sel_nxt       = sel_r + 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = sel_r + 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = wrg_pkg::SEL_VAR;
          state_nxt     = S_DIVV;
        end
      end
      S_DIVV: begin
        cmd.div_sel = wrg_pkg::SEL_VAR;
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: if (sts.sqrt_done) state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      sel_r   <= wrg_pkg::SEL_X;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end
endmodule

[hdl/weighted_radius_of_gyration.sv]
// ----------------------------------------------------------------------------
// weighted_radius_of_gyration
// density-weighted centroid and radius of gyration over a streamed point grid
// ----------------------------------------------------------------------------
// channel   dir  words
// in_ch     in   one grid point: x, y, z (Q8.8), weight, last_point
// out_ch    out  one result per grid: centroid x, y, z, radius, status
//
// points are taken one per cycle while loading; the point memory write port
// sets that rate. after the last point the block runs three centroid
// divides and one variance divide through the 64-step divider, one memory
// read per point plus pipeline drain, 32 root steps and the output load; an
// overflowed or zero-weight grid goes straight from the check to the output
// load. reset is synchronous and clears sums, count and control; memory is
// not cleared. a pending result waits in the output register while the
// next grid loads.
// ----------------------------------------------------------------------------
module weighted_radius_of_gyration #(
  parameter int MAX_POINTS = wrg_pkg::DEF_MAX_POINTS
) (
  input  logic      clk,
  input  logic      rst_n,
  wrg_in_if.sink    in_ch,
  wrg_out_if.source out_ch
);
  wrg_pkg::cmd_t cmd;
  wrg_pkg::sts_t sts;

  wrg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_last(in_ch.last_point),
    .in_ready(in_ch.ready), .sts(sts), .cmd(cmd)
  );

  wrg_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the weighted radius of gyration block: streams
// point grids through the input channel, predicts centroid, radius and status
// per grid, and compares each result word in order under random stalls
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [wrg_pkg::COORD_W-1:0] cx;
    logic signed [wrg_pkg::COORD_W-1:0] cy;
    logic signed [wrg_pkg::COORD_W-1:0] cz;
    logic [wrg_pkg::COORD_W-1:0]        radius;
    logic [wrg_pkg::STATUS_W-1:0]       status;
  } grid_result_t;

  typedef struct {
    logic signed [wrg_pkg::COORD_W-1:0] x;
    logic signed [wrg_pkg::COORD_W-1:0] y;
    logic signed [wrg_pkg::COORD_W-1:0] z;
    logic [wrg_pkg::WEIGHT_W-1:0]       w;
  } grid_point_t;

  localparam int WATCHDOG_LIMIT = 60000;

  logic clk;
  logic rst_n;
  wrg_in_if  in_ch ();
  wrg_out_if out_ch ();

  weighted_radius_of_gyration uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  grid_result_t expected_results[$];
  grid_point_t  grid_points[$];
  longint       coord_sum[3];
  longint unsigned weight_sum;
  bit           grid_ovf;

  int src_idle_pct;
  int snk_idle_pct;
  int hold_cycles;
  int errors;
  int idle_cycles;
  int points_sent;
  int grids_checked;
  int ovf_seen;
  int zero_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint round_div(longint n, longint unsigned t);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = (mag + t / 2) / t;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void clear_grid();
    grid_points.delete();
    coord_sum = '{0, 0, 0};
    weight_sum = 0;
    grid_ovf = 1'b0;
  endfunction

  // accumulate one accepted point, emit an expectation on the last one
  function automatic void predict_point(grid_point_t p, bit last);
    grid_result_t r;
    longint c[3];
    longint d;
    longint unsigned sq;
    longint unsigned term;
    longint unsigned spread;
    longint unsigned root;
    if (grid_points.size() < wrg_pkg::DEF_MAX_POINTS) begin
      grid_points.push_back(p);
      coord_sum[0] += longint'(p.x) * longint'(p.w);
      coord_sum[1] += longint'(p.y) * longint'(p.w);
      coord_sum[2] += longint'(p.z) * longint'(p.w);
      weight_sum += p.w;
    end else begin
      grid_ovf = 1'b1;
    end
    if (!last) return;
    r = '{cx: '0, cy: '0, cz: '0, radius: '0, status: wrg_pkg::ST_OK};
    if (grid_ovf) begin
      r.status = wrg_pkg::ST_OVF;
    end else if (weight_sum == 0) begin
      r.status = wrg_pkg::ST_ZERO;
    end else begin
      for (int k = 0; k < 3; k++) c[k] = round_div(coord_sum[k], weight_sum);
      spread = 0;
      foreach (grid_points[i]) begin
        d = longint'(grid_points[i].x) - c[0];
        sq = d * d;
        d = longint'(grid_points[i].y) - c[1];
        sq += d * d;
        d = longint'(grid_points[i].z) - c[2];
        sq += d * d;
        term = sq * grid_points[i].w;
        spread = (spread > 64'hFFFF_FFFF_FFFF_FFFF - term) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : spread + term;
      end
      root = int_sqrt(spread / weight_sum);
      r.cx = c[0][wrg_pkg::COORD_W-1:0];
      r.cy = c[1][wrg_pkg::COORD_W-1:0];
      r.cz = c[2][wrg_pkg::COORD_W-1:0];
      r.radius = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
    end
    expected_results.push_back(r);
    clear_grid();
  endfunction

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [15:0] w, bit last);
    grid_point_t p;
    p = '{x: x, y: y, z: z, w: w};
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.x_coord    <= x;
    in_ch.y_coord    <= y;
    in_ch.z_coord    <= z;
    in_ch.weight     <= w;
    in_ch.last_point <= last;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
    predict_point(p, last);
  endtask

  task automatic send_random_grid(int n);
    int mode;
    logic [15:0] w;
    mode = $urandom_range(9);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = '0;
        1: w = 16'($urandom_range(3));
        default: w = 16'($urandom);
      endcase
      send_point(16'($urandom), 16'($urandom), 16'($urandom), w, i == n - 1);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_point(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b1);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1);
    send_point(16'h0100, 16'hFF00, 16'h0000, 16'h0000, 1'b1);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b1);
    send_point(16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 1'b0);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
    // centroid exactly halfway, rounds away from zero
    send_point(16'h0000, 16'h0001, 16'hFFFF, 16'h0002, 1'b0);
    send_point(16'hFFFF, 16'h0000, 16'h0000, 16'h0002, 1'b1);
    for (int i = 0; i < 4; i++)
      send_point(16'($urandom), 16'($urandom), 16'($urandom), 16'h0, i == 3);
    wait_drained();
  endtask

  task automatic test_random(int items, int s_pct, int r_pct);
    int goal;
    src_idle_pct = s_pct;
    snk_idle_pct = r_pct;
    goal = points_sent + items;
    while (points_sent < goal)
      send_random_grid(($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12));
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 2500;
    for (int g = 0; g < 4; g++) send_random_grid($urandom_range(1, 6));
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    grid_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        grids_checked++;
        if (e.status == wrg_pkg::ST_OVF) ovf_seen++;
        if (e.status == wrg_pkg::ST_ZERO) zero_seen++;
        if (out_ch.centroid_x !== e.cx) begin
          $error("centroid_x exp %0d got %0d", e.cx, out_ch.centroid_x);
          errors++;
        end
        if (out_ch.centroid_y !== e.cy) begin
          $error("centroid_y exp %0d got %0d", e.cy, out_ch.centroid_y);
          errors++;
        end
        if (out_ch.centroid_z !== e.cz) begin
          $error("centroid_z exp %0d got %0d", e.cz, out_ch.centroid_z);
          errors++;
        end
        if (out_ch.radius !== e.radius) begin
          $error("radius exp %0d got %0d", e.radius, out_ch.radius);
          errors++;
        end
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    points_sent = 0;
    grids_checked = 0;
    ovf_seen = 0;
    zero_seen = 0;
    hold_cycles = 0;
    src_idle_pct = 34;
    snk_idle_pct = 54;
    clear_grid();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.z_coord = '0;
    in_ch.weight = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_random(400, 34, 54);
    test_backpressure();
    test_random(400, 54, 34);
    test_random(400, 0, 0);

    repeat (600) @(posedge clk);
    $display("sent %0d points, checked %0d grid results", points_sent, grids_checked);
    $display("overflowed grids %0d, zero-weight grids %0d", ovf_seen, zero_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[weighted_radius_of_gyration.f]
hdl/wrg_pkg.sv
hdl/wrg_if.sv
hdl/wrg_div.sv
hdl/wrg_dp.sv
hdl/wrg_ctrl.sv
hdl/weighted_radius_of_gyration.sv
tb/tb_top.sv
